// File: hdl/p3b_pkg.sv
// ----------------------------------------------------------------------------
// p3b_pkg
// Types, constants and shared helpers of the ParamPoly3 to Bezier datapath.
// ----------------------------------------------------------------------------
package p3b_pkg;

  localparam logic [14:0] QUARTER_TURN = 15'd16384;

  // Odd sine polynomial coefficients, Q30
  localparam logic signed [32:0] SIN_K1 = 33'sd1686629713;
  localparam logic signed [32:0] SIN_K3 = 33'sd693598670;
  localparam logic signed [32:0] SIN_K5 = 33'sd85569307;
  localparam logic signed [32:0] SIN_K7 = 33'sd5026996;
  localparam logic signed [32:0] SIN_K9 = 33'sd172272;

  // Heading quadrant codes
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  typedef struct packed {
    logic signed [31:0] coef_dv;
    logic signed [31:0] coef_cv;
    logic signed [31:0] coef_bv;
    logic signed [31:0] coef_du;
    logic signed [31:0] coef_cu;
    logic signed [31:0] coef_bu;
    logic               range_mode;
    logic        [30:0] seg_length;
    logic        [15:0] heading;
    logic signed [31:0] start_y;
    logic signed [31:0] start_x;
  } seg_t;

  typedef struct packed {
    logic signed [17:0] sn;
    logic signed [17:0] cs;
  } trig_t;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    trig_t              trig;
  } pass_t;

  typedef struct packed {
    logic signed [31:0] bu;
    logic signed [31:0] cu;
    logic signed [31:0] du;
    logic signed [31:0] bv;
    logic signed [31:0] cv;
    logic signed [31:0] dv;
  } coef_t;

  typedef struct packed {
    logic signed [33:0] u1;
    logic signed [33:0] u2;
    logic signed [33:0] u3;
    logic signed [33:0] v1;
    logic signed [33:0] v2;
    logic signed [33:0] v3;
  } off_t;

  // First member is the top; p0_x lands in the lowest bits
  typedef struct packed {
    logic signed [31:0] p3_y;
    logic signed [31:0] p3_x;
    logic signed [31:0] p2_y;
    logic signed [31:0] p2_x;
    logic signed [31:0] p1_y;
    logic signed [31:0] p1_x;
    logic signed [31:0] p0_y;
    logic signed [31:0] p0_x;
  } pts_t;

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    if (v > 48'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -48'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

// File: hdl/p3b_sincos.sv
// ----------------------------------------------------------------------------
// p3b_sincos
// Seven-stage sine/cosine of the binary heading, odd polynomial per quadrant.
// ----------------------------------------------------------------------------
module p3b_sincos
  import p3b_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  seg_t  in_seg_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output seg_t  out_seg_o,
  output trig_t out_trig_o
);

  localparam int NS = 7;
  localparam logic signed [32:0] POLY_K [0:3] = '{SIN_K7, SIN_K5, SIN_K3, SIN_K1};

  logic [NS-1:0] vld_q;
  logic [NS-1:0] en;

  seg_t               seg_q [0:NS-1];
  logic        [14:0] ta_q  [0:4];
  logic        [14:0] tb_q  [0:4];
  logic        [31:0] x2a_q [0:3];
  logic        [31:0] x2b_q [0:3];
  logic signed [32:0] sa_q  [0:4];
  logic signed [32:0] sb_q  [0:4];
  logic signed [33:0] pa_q, pb_q;
  trig_t              trig_q;

  logic [14:0] ta_d, tb_d;
  logic [29:0] sqa, sqb;
  logic signed [64:0] pa_d, pb_d;
  logic [16:0] qa, qb;
  logic signed [17:0] a_pos, b_pos;
  trig_t trig_d;

  function automatic logic signed [32:0] poly_step(input logic signed [32:0] kc,
                                                   input logic signed [32:0] s,
                                                   input logic [31:0] x2);
    logic signed [65:0] p;
    p = s * $signed({1'b0, x2});
    return kc - 33'(p >>> 30);
  endfunction

  function automatic logic [16:0] q16_clamp(input logic signed [33:0] p);
    logic signed [34:0] r;
    r = ($signed({p[33], p}) + 35'sd8192) >>> 14;
    if (r < 0) begin
      return 17'd0;
    end else if (r > 35'sd65536) begin
      return 17'd65536;
    end
    return r[16:0];
  endfunction

  always_comb begin
    en[NS-1] = !vld_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign ta_d = {1'b0, in_seg_i.heading[13:0]};
  assign tb_d = QUARTER_TURN - ta_d;
  assign sqa  = ta_d * ta_d;
  assign sqb  = tb_d * tb_d;
  assign pa_d = sa_q[4] * $signed({1'b0, ta_q[4], 16'b0});
  assign pb_d = sb_q[4] * $signed({1'b0, tb_q[4], 16'b0});
  assign qa   = q16_clamp(pa_q);
  assign qb   = q16_clamp(pb_q);
  assign a_pos = $signed({1'b0, qa});
  assign b_pos = $signed({1'b0, qb});

  always_comb begin
    unique case (seg_q[5].heading[15:14])
      QUAD_0: begin
        trig_d.sn = a_pos;
        trig_d.cs = b_pos;
      end
      QUAD_1: begin
        trig_d.sn = b_pos;
        trig_d.cs = -a_pos;
      end
      QUAD_2: begin
        trig_d.sn = -a_pos;
        trig_d.cs = -b_pos;
      end
      default: begin
        trig_d.sn = -b_pos;
        trig_d.cs = a_pos;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      seg_q[0] <= in_seg_i;
      ta_q[0]  <= ta_d;
      tb_q[0]  <= tb_d;
      x2a_q[0] <= {sqa, 2'b00};
      x2b_q[0] <= {sqb, 2'b00};
      sa_q[0]  <= SIN_K9;
      sb_q[0]  <= SIN_K9;
    end
    // Horner steps, one multiply per stage for each of the two angles
    for (int k = 1; k <= 4; k++) begin
      if (en[k]) begin
        seg_q[k] <= seg_q[k-1];
        ta_q[k]  <= ta_q[k-1];
        tb_q[k]  <= tb_q[k-1];
        sa_q[k]  <= poly_step(POLY_K[k-1], sa_q[k-1], x2a_q[k-1]);
        sb_q[k]  <= poly_step(POLY_K[k-1], sb_q[k-1], x2b_q[k-1]);
      end
    end
    for (int k = 1; k <= 3; k++) begin
      if (en[k]) begin
        x2a_q[k] <= x2a_q[k-1];
        x2b_q[k] <= x2b_q[k-1];
      end
    end
    if (en[5]) begin
      seg_q[5] <= seg_q[4];
      pa_q     <= 34'(pa_d >>> 30);
      pb_q     <= 34'(pb_d >>> 30);
    end
    if (en[6]) begin
      seg_q[6] <= seg_q[5];
      trig_q   <= trig_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[NS-1];
  assign out_seg_o   = seg_q[NS-1];
  assign out_trig_o  = trig_q;

  a_quad0_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_seg_o.heading[15:14] == QUAD_0)
      |-> (out_trig_o.sn >= 0 && out_trig_o.cs >= 0))
    else $error("quadrant 0 sine or cosine negative");

  a_quad2_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_seg_o.heading[15:14] == QUAD_2)
      |-> (out_trig_o.sn <= 0 && out_trig_o.cs <= 0))
    else $error("quadrant 2 sine or cosine positive");

endmodule

// File: hdl/p3b_scale.sv
// ----------------------------------------------------------------------------
// p3b_scale
// Three-stage arc-length rescale of the coefficients by L, L^2 and L^3.
// ----------------------------------------------------------------------------
module p3b_scale
  import p3b_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  seg_t  in_seg_i,
  input  trig_t in_trig_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output coef_t out_coef_o,
  output pass_t out_pass_o
);

  localparam int NS = 3;

  logic [NS-1:0] vld_q;
  logic [NS-1:0] en;

  coef_t       coef_q [0:NS-1];
  pass_t       pass_q [0:NS-1];
  logic        arc_q  [0:1];
  logic [30:0] len_q  [0:1];

  coef_t c0_d, c1_d, c2_d;
  pass_t pass_d;

  function automatic logic signed [31:0] mul_len(input logic signed [31:0] k,
                                                 input logic [30:0] len);
    logic signed [63:0] p;
    p = k * $signed({1'b0, len});
    return sat32(48'((p + 64'sd32768) >>> 16));
  endfunction

  always_comb begin
    en[NS-1] = !vld_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign pass_d.start_x = in_seg_i.start_x;
  assign pass_d.start_y = in_seg_i.start_y;
  assign pass_d.trig    = in_trig_i;

  always_comb begin
    c0_d.bu = in_seg_i.coef_bu;
    c0_d.cu = in_seg_i.coef_cu;
    c0_d.du = in_seg_i.coef_du;
    c0_d.bv = in_seg_i.coef_bv;
    c0_d.cv = in_seg_i.coef_cv;
    c0_d.dv = in_seg_i.coef_dv;
    if (in_seg_i.range_mode) begin
      c0_d.bu = mul_len(in_seg_i.coef_bu, in_seg_i.seg_length);
      c0_d.cu = mul_len(in_seg_i.coef_cu, in_seg_i.seg_length);
      c0_d.du = mul_len(in_seg_i.coef_du, in_seg_i.seg_length);
      c0_d.bv = mul_len(in_seg_i.coef_bv, in_seg_i.seg_length);
      c0_d.cv = mul_len(in_seg_i.coef_cv, in_seg_i.seg_length);
      c0_d.dv = mul_len(in_seg_i.coef_dv, in_seg_i.seg_length);
    end
  end

  always_comb begin
    c1_d = coef_q[0];
    if (arc_q[0]) begin
      c1_d.cu = mul_len(coef_q[0].cu, len_q[0]);
      c1_d.du = mul_len(coef_q[0].du, len_q[0]);
      c1_d.cv = mul_len(coef_q[0].cv, len_q[0]);
      c1_d.dv = mul_len(coef_q[0].dv, len_q[0]);
    end
  end

  always_comb begin
    c2_d = coef_q[1];
    if (arc_q[1]) begin
      c2_d.du = mul_len(coef_q[1].du, len_q[1]);
      c2_d.dv = mul_len(coef_q[1].dv, len_q[1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      coef_q[0] <= c0_d;
      pass_q[0] <= pass_d;
      arc_q[0]  <= in_seg_i.range_mode;
      len_q[0]  <= in_seg_i.seg_length;
    end
    if (en[1]) begin
      coef_q[1] <= c1_d;
      pass_q[1] <= pass_q[0];
      arc_q[1]  <= arc_q[0];
      len_q[1]  <= len_q[0];
    end
    if (en[2]) begin
      coef_q[2] <= c2_d;
      pass_q[2] <= pass_q[1];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[NS-1];
  assign out_coef_o  = coef_q[NS-1];
  assign out_pass_o  = pass_q[NS-1];

endmodule

// File: hdl/p3b_offset.sv
// ----------------------------------------------------------------------------
// p3b_offset
// One-stage local control offsets, division by three rounded to nearest.
// ----------------------------------------------------------------------------
module p3b_offset
  import p3b_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  coef_t in_coef_i,
  input  pass_t in_pass_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output off_t  out_off_o,
  output pass_t out_pass_o
);

  // Bias that lifts every operand above zero, a multiple of three
  localparam logic signed [36:0] DIV3_BIAS = 37'sd51539607552;
  localparam logic signed [36:0] DIV3_BASE = 37'sd17179869184;

  logic  vld_q;
  logic  en;
  off_t  off_q;
  pass_t pass_q;
  off_t  off_d;

  // floor((v + 1) / 3): split w = a*2^18 + b, since 2^18 = 1 mod 3
  function automatic logic signed [33:0] rnd3(input logic signed [33:0] v);
    logic signed [36:0] ws;
    logic        [35:0] w;
    logic        [18:0] s;
    logic        [39:0] ps;
    logic        [35:0] q;
    logic signed [36:0] r;
    ws = 37'(v) + 37'sd1 + DIV3_BIAS;
    w  = ws[35:0];
    s  = {1'b0, w[35:18]} + {1'b0, w[17:0]};
    ps = s * 21'd699051;
    q  = 36'(w[35:18]) * 36'(17'd87381) + 36'(ps[39:21]);
    r  = $signed({1'b0, q}) - DIV3_BASE;
    return r[33:0];
  endfunction

  always_comb begin
    off_d.u1 = rnd3(34'(in_coef_i.bu));
    off_d.u2 = rnd3(34'(in_coef_i.bu) + 34'(in_coef_i.bu) + 34'(in_coef_i.cu));
    off_d.u3 = 34'(in_coef_i.bu) + 34'(in_coef_i.cu) + 34'(in_coef_i.du);
    off_d.v1 = rnd3(34'(in_coef_i.bv));
    off_d.v2 = rnd3(34'(in_coef_i.bv) + 34'(in_coef_i.bv) + 34'(in_coef_i.cv));
    off_d.v3 = 34'(in_coef_i.bv) + 34'(in_coef_i.cv) + 34'(in_coef_i.dv);
  end

  assign en = !vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      off_q  <= off_d;
      pass_q <= in_pass_i;
    end
  end

  assign in_ready_o  = en;
  assign out_valid_o = vld_q;
  assign out_off_o   = off_q;
  assign out_pass_o  = pass_q;

endmodule

// File: hdl/p3b_rotate.sv
// ----------------------------------------------------------------------------
// p3b_rotate
// Two-stage rotation by the heading and translation to the start point.
// ----------------------------------------------------------------------------
module p3b_rotate
  import p3b_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  off_t  in_off_i,
  input  pass_t in_pass_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output pts_t  out_pts_o
);

  localparam int NS = 2;

  logic [NS-1:0] vld_q;
  logic [NS-1:0] en;

  logic signed [51:0] uc_q [0:2];
  logic signed [51:0] vs_q [0:2];
  logic signed [51:0] us_q [0:2];
  logic signed [51:0] vc_q [0:2];
  logic signed [31:0] sx_q, sy_q;
  pts_t               pts_q;

  logic signed [33:0] u_in [0:2];
  logic signed [33:0] v_in [0:2];
  logic signed [31:0] px_d [0:2];
  logic signed [31:0] py_d [0:2];
  pts_t               pts_d;

  function automatic logic signed [31:0] place(input logic signed [31:0] s,
                                               input logic signed [51:0] pa,
                                               input logic signed [51:0] pb,
                                               input logic neg);
    logic signed [52:0] t;
    logic signed [36:0] d;
    t = neg ? (53'(pa) - 53'(pb)) : (53'(pa) + 53'(pb));
    d = 37'((t + 53'sd32768) >>> 16);
    return sat32(48'(s) + 48'(d));
  endfunction

  always_comb begin
    en[NS-1] = !vld_q[NS-1] || out_ready_i;
    en[0]    = !vld_q[0] || en[1];
  end

  assign u_in[0] = in_off_i.u1;
  assign u_in[1] = in_off_i.u2;
  assign u_in[2] = in_off_i.u3;
  assign v_in[0] = in_off_i.v1;
  assign v_in[1] = in_off_i.v2;
  assign v_in[2] = in_off_i.v3;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      px_d[i] = place(sx_q, uc_q[i], vs_q[i], 1'b1);
      py_d[i] = place(sy_q, us_q[i], vc_q[i], 1'b0);
    end
    pts_d.p0_x = sx_q;
    pts_d.p0_y = sy_q;
    pts_d.p1_x = px_d[0];
    pts_d.p1_y = py_d[0];
    pts_d.p2_x = px_d[1];
    pts_d.p2_y = py_d[1];
    pts_d.p3_x = px_d[2];
    pts_d.p3_y = py_d[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      if (en[1]) vld_q[1] <= vld_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        uc_q[i] <= u_in[i] * in_pass_i.trig.cs;
        vs_q[i] <= v_in[i] * in_pass_i.trig.sn;
        us_q[i] <= u_in[i] * in_pass_i.trig.sn;
        vc_q[i] <= v_in[i] * in_pass_i.trig.cs;
      end
      sx_q <= in_pass_i.start_x;
      sy_q <= in_pass_i.start_y;
    end
    if (en[1]) begin
      pts_q <= pts_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[NS-1];
  assign out_pts_o   = pts_q;

endmodule

// File: hdl/parampoly3_to_bezier_points_core.sv
// ----------------------------------------------------------------------------
// parampoly3_to_bezier_points_core
// ParamPoly3 road segment to four cubic Bezier control points in Q16.16.
// ----------------------------------------------------------------------------
// Pipeline: 7 sine/cosine, 3 length rescale, 1 offset and 2 rotate stages
//   from input request to result request.
// Throughput: one segment per cycle unless stalled; every stage holds its
//   own valid bit, so a bubble anywhere lets the stages behind it advance.
// Reset: rst_ni clears all valid bits asynchronously; payload is not reset.
// ----------------------------------------------------------------------------
module parampoly3_to_bezier_points_core
  import p3b_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  // start_x[31:0], start_y[63:32], heading[79:64], seg_length[110:80],
  // coef_bu[142:111], coef_cu[174:143], coef_du[206:175], coef_bv[238:207],
  // coef_cv[270:239], coef_dv[302:271], zero pad[303]
  input  logic [303:0] s_axis_tdata,
  // range_mode[0]
  input  logic [0:0]   s_axis_tuser,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // p0_x[31:0], p0_y[63:32], p1_x[95:64], p1_y[127:96], p2_x[159:128],
  // p2_y[191:160], p3_x[223:192], p3_y[255:224]
  output logic [255:0] m_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready
);

  seg_t  in_seg;
  seg_t  sc_seg;
  trig_t sc_trig;
  coef_t sl_coef;
  pass_t sl_pass;
  off_t  of_off;
  pass_t of_pass;
  pts_t  rt_pts;

  logic sc_valid, sc_ready;
  logic sl_valid, sl_ready;
  logic of_valid, of_ready;

  // Unpack the request into its fields
  assign in_seg.start_x    = s_axis_tdata[31:0];
  assign in_seg.start_y    = s_axis_tdata[63:32];
  assign in_seg.heading    = s_axis_tdata[79:64];
  assign in_seg.seg_length = s_axis_tdata[110:80];
  assign in_seg.range_mode = s_axis_tuser[0];
  assign in_seg.coef_bu    = s_axis_tdata[142:111];
  assign in_seg.coef_cu    = s_axis_tdata[174:143];
  assign in_seg.coef_du    = s_axis_tdata[206:175];
  assign in_seg.coef_bv    = s_axis_tdata[238:207];
  assign in_seg.coef_cv    = s_axis_tdata[270:239];
  assign in_seg.coef_dv    = s_axis_tdata[302:271];

  // Sine and cosine of the heading; the segment rides along
  p3b_sincos u_sincos (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_seg_i    (in_seg),
    .out_valid_o (sc_valid),
    .out_ready_i (sc_ready),
    .out_seg_o   (sc_seg),
    .out_trig_o  (sc_trig)
  );

  // Rescale coefficients to the normalized parameter in arc-length mode
  p3b_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sc_valid),
    .in_ready_o  (sc_ready),
    .in_seg_i    (sc_seg),
    .in_trig_i   (sc_trig),
    .out_valid_o (sl_valid),
    .out_ready_i (sl_ready),
    .out_coef_o  (sl_coef),
    .out_pass_o  (sl_pass)
  );

  // Local control offsets b/3, (2b+c)/3 and b+c+d
  p3b_offset u_offset (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sl_valid),
    .in_ready_o  (sl_ready),
    .in_coef_i   (sl_coef),
    .in_pass_i   (sl_pass),
    .out_valid_o (of_valid),
    .out_ready_i (of_ready),
    .out_off_o   (of_off),
    .out_pass_o  (of_pass)
  );

  // Rotate, translate, saturate; last stage is the output register
  p3b_rotate u_rotate (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (of_valid),
    .in_ready_o  (of_ready),
    .in_off_i    (of_off),
    .in_pass_i   (of_pass),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_pts_o   (rt_pts)
  );

  assign m_axis_tdata = rt_pts;

  // Back-pressure only arises when a finished result waits at the output
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a waiting result");

endmodule
